FILE: rtl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants for the 3x3 zero-padded box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int SUM_W      = 12;
    localparam int LINE_W     = 2 * PIX_W;

    localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd5;
    localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd3;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // Division by nine as a multiply by a scaled reciprocal; exact for sums
    // well beyond the largest neighbourhood sum.
    localparam int               DIV9_SHIFT = 16;
    localparam logic [12:0]      DIV9_RECIP = 13'd7282;
    localparam int               DIV9_PROD_W = SUM_W + 13;

    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
        logic [DIV9_PROD_W-1:0] prod;
        prod = DIV9_PROD_W'(sum) * DIV9_PROD_W'(DIV9_RECIP);
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

FILE: rtl/bf3_line_mem.sv
// ----------------------------------------------------------------------------
// bf3_line_mem
// Two line buffers in one synchronous memory with same-entry forwarding.
// ----------------------------------------------------------------------------
module bf3_line_mem #(
    parameter int DEPTH = bf3_pkg::MAX_WIDTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [bf3_pkg::LINE_W-1:0]  i_wr_data,
    output logic [bf3_pkg::LINE_W-1:0]  o_rd_data
);

    logic [bf3_pkg::LINE_W-1:0] r_mem [DEPTH];
    logic [bf3_pkg::LINE_W-1:0] r_rd_raw;
    logic [bf3_pkg::LINE_W-1:0] r_fwd_data;
    logic                       r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_raw   <= r_mem[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_raw;

endmodule

FILE: rtl/box_filter_3x3_zero_pad.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_zero_pad
// Streaming 3x3 mean filter with zero padding and two line buffers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat content
//  s_axis    in         tdata[7:0] pixel
//  m_axis    out        tdata: value, row, column; tlast: last of run;
//                       tuser: end of image
//  cfg       in         i_cfg_addr selects width or height register
//
// A pixel is taken per cycle as long as each causes at most one result and the
// output is not stalled; results leave one per cycle through a single output
// register while the output is ready, so a pixel causing several results holds
// up the input while they leave. The line memory is read when a pixel is taken
// and written back when the pixel leaves the holding register.
// Reset clears the position counters and the window; the line memory needs
// no clearing. A stalled output backs up into the input once the output
// register, the results of one pixel and one held pixel are all waiting.
// ----------------------------------------------------------------------------
module box_filter_3x3_zero_pad #(
    parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bf3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [bf3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] filtered_value, [19:8] out_row, [29:20] out_col, [31:30] zero
    output logic [31:0]                    m_axis_tdata,
    output logic                           m_axis_tlast,   // last_of_run
    output logic [0:0]                     m_axis_tuser    // [0] end_of_image
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = bf3_pkg::PIX_W;
    localparam int SW = bf3_pkg::SUM_W;
    localparam int ORW = bf3_pkg::OUT_ROW_W;
    localparam int OCW = bf3_pkg::OUT_COL_W;

    logic [bf3_pkg::CFG_W_W-1:0] r_cfg_w;
    logic [bf3_pkg::CFG_H_W-1:0] r_cfg_h;
    logic [WW-1:0]               w_eff;
    logic [HW-1:0]               h_eff;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          in_acc;
    logic          last_col;
    logic          last_row;

    logic          r_b_valid;
    logic [PW-1:0] r_b_pix;
    logic [CW-1:0] r_b_c;
    logic [RW-1:0] r_b_r;
    logic          r_b_lc;
    logic          r_b_lr;
    logic          consume;

    logic [bf3_pkg::LINE_W-1:0] rd_data;
    logic [bf3_pkg::LINE_W-1:0] wr_data;

    logic [PW-1:0] r_win [6];
    logic [PW-1:0] win_e [6];
    logic [PW-1:0] t1;
    logic [PW-1:0] t2;

    logic [SW-1:0]  cand_sum [4];
    logic [ORW-1:0] cand_row [4];
    logic [OCW-1:0] cand_col [4];
    logic           cand_v   [4];

    logic [SW-1:0]  n_q_sum  [4];
    logic [ORW-1:0] n_q_row  [4];
    logic [OCW-1:0] n_q_col  [4];
    logic           n_q_last [4];
    logic           n_q_eoi  [4];
    logic [2:0]     n_q_cnt;

    logic [SW-1:0]  r_q_sum  [4];
    logic [ORW-1:0] r_q_row  [4];
    logic [OCW-1:0] r_q_col  [4];
    logic           r_q_last [4];
    logic           r_q_eoi  [4];
    logic [2:0]     r_q_cnt;
    logic           move;

    logic           r_o_valid;
    logic [PW-1:0]  r_o_val;
    logic [ORW-1:0] r_o_row;
    logic [OCW-1:0] r_o_col;
    logic           r_o_last;
    logic           r_o_eoi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bf3_pkg::IMAGE_WIDTH_RST;
            r_cfg_h <= bf3_pkg::IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (bf3_pkg::t_cfg_reg'(i_cfg_addr))
                bf3_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_w <= i_cfg_data[bf3_pkg::CFG_W_W-1:0];
                end
                bf3_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_h <= i_cfg_data[bf3_pkg::CFG_H_W-1:0];
                end
                default: begin
                    r_cfg_w <= r_cfg_w;
                end
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
    end

    assign last_col      = (32'(r_col) + 32'd1) >= 32'(w_eff);
    assign last_row      = (32'(r_row) + 32'd1) >= 32'(h_eff);
    assign move          = (r_q_cnt != 3'd0) && (!r_o_valid || m_axis_tready);
    assign consume       = r_b_valid && ((r_q_cnt == 3'd0) || ((r_q_cnt == 3'd1) && move));
    assign s_axis_tready = !r_b_valid || consume;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
                r_b_valid <= 1'b1;
            end else if (consume) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_pix <= s_axis_tdata;
            r_b_c   <= r_col;
            r_b_r   <= r_row;
            r_b_lc  <= last_col;
            r_b_lr  <= last_row;
        end
    end

    assign wr_data = {rd_data[PW-1:0], r_b_pix};

    bf3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (consume),
        .i_wr_addr (r_b_c),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    always_comb begin
        logic [9:0]  col_a;
        logic [9:0]  col_b;
        logic [9:0]  cur;
        logic [9:0]  low_a;
        logic [9:0]  low_b;
        logic [9:0]  low_cur;
        logic [2:0]  idx;
        logic [ORW-1:0] row_up;
        logic [ORW-1:0] row_here;
        logic [OCW-1:0] col_left;
        logic [OCW-1:0] col_here;

        for (int i = 0; i < 6; i++) begin
            win_e[i] = (r_b_c == '0) ? '0 : r_win[i];
        end
        t1 = (r_b_r >= RW'(1)) ? rd_data[PW-1:0] : '0;
        t2 = (32'(r_b_r) >= 32'd2) ? rd_data[2*PW-1:PW] : '0;

        col_a   = 10'(win_e[0]) + 10'(win_e[1]) + 10'(win_e[2]);
        col_b   = 10'(win_e[3]) + 10'(win_e[4]) + 10'(win_e[5]);
        cur     = 10'(t2) + 10'(t1) + 10'(r_b_pix);
        low_a   = 10'(win_e[1]) + 10'(win_e[2]);
        low_b   = 10'(win_e[4]) + 10'(win_e[5]);
        low_cur = 10'(t1) + 10'(r_b_pix);

        row_up   = ORW'(r_b_r - RW'(1));
        row_here = ORW'(r_b_r);
        col_left = OCW'(r_b_c - CW'(1));
        col_here = OCW'(r_b_c);

        cand_v[0]   = (r_b_r != '0) && (r_b_c != '0);
        cand_sum[0] = SW'(col_a) + SW'(col_b) + SW'(cur);
        cand_row[0] = row_up;
        cand_col[0] = col_left;
        cand_v[1]   = (r_b_r != '0) && r_b_lc;
        cand_sum[1] = SW'(col_a) + SW'(cur);
        cand_row[1] = row_up;
        cand_col[1] = col_here;
        cand_v[2]   = r_b_lr && (r_b_c != '0);
        cand_sum[2] = SW'(low_a) + SW'(low_b) + SW'(low_cur);
        cand_row[2] = row_here;
        cand_col[2] = col_left;
        cand_v[3]   = r_b_lr && r_b_lc;
        cand_sum[3] = SW'(low_a) + SW'(low_cur);
        cand_row[3] = row_here;
        cand_col[3] = col_here;

        for (int i = 0; i < 4; i++) begin
            n_q_sum[i]  = '0;
            n_q_row[i]  = '0;
            n_q_col[i]  = '0;
            n_q_last[i] = 1'b0;
            n_q_eoi[i]  = 1'b0;
        end
        idx = 3'd0;
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k]) begin
                n_q_sum[idx[1:0]] = cand_sum[k];
                n_q_row[idx[1:0]] = cand_row[k];
                n_q_col[idx[1:0]] = cand_col[k];
                n_q_eoi[idx[1:0]] = (k == 3);
                idx = idx + 3'd1;
            end
        end
        if (idx != 3'd0) begin
            n_q_last[2'(idx - 3'd1)] = 1'b1;
        end
        n_q_cnt = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (consume) begin
            r_win[3] <= win_e[0];
            r_win[4] <= win_e[1];
            r_win[5] <= win_e[2];
            r_win[0] <= t2;
            r_win[1] <= t1;
            r_win[2] <= r_b_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 3'd0;
        end else if (consume) begin
            r_q_cnt <= n_q_cnt;
        end else if (move) begin
            r_q_cnt <= r_q_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            for (int i = 0; i < 4; i++) begin
                r_q_sum[i]  <= n_q_sum[i];
                r_q_row[i]  <= n_q_row[i];
                r_q_col[i]  <= n_q_col[i];
                r_q_last[i] <= n_q_last[i];
                r_q_eoi[i]  <= n_q_eoi[i];
            end
        end else if (move) begin
            for (int i = 0; i < 3; i++) begin
                r_q_sum[i]  <= r_q_sum[i+1];
                r_q_row[i]  <= r_q_row[i+1];
                r_q_col[i]  <= r_q_col[i+1];
                r_q_last[i] <= r_q_last[i+1];
                r_q_eoi[i]  <= r_q_eoi[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (move) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_o_val  <= bf3_pkg::div9(r_q_sum[0]);
            r_o_row  <= r_q_row[0];
            r_o_col  <= r_q_col[0];
            r_o_last <= r_q_last[0];
            r_o_eoi  <= r_q_eoi[0];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b00, r_o_col, r_o_row, r_o_val};
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_eoi;

endmodule
